### sv/mec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mec_pkg - shared types and constants of the escape count unit
// Formats, register indexes, payload structs, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mec_pkg;

    localparam int FRAC_BITS  = 28;            // fraction bits of c, z and |z|^2
    localparam int ITER_BITS  = 16;            // bits of the iteration counter
    localparam int C_W        = 32;            // width of a c component
    localparam int LIM_W      = 16;            // width of the iteration limit
    localparam int MAG_W      = 36;            // width of |z|^2 and bailout
    localparam int Z_W        = 39;            // width of a z component
    localparam int OP_W       = 33;            // multiplier operand width
    localparam int P_W        = 2 * OP_W;      // multiplier product width
    localparam int Q_W        = 37;            // width of cardioid/bulb terms
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 36;

    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BAILOUT_SQ = CFG_IDX_W'(1);

    localparam logic [LIM_W-1:0] LIMIT_RESET   = LIM_W'(256);
    localparam logic [MAG_W-1:0] BAILOUT_RESET = MAG_W'(64'd1 << 30);

    typedef struct packed {
        logic signed [C_W-1:0] c_real;
        logic signed [C_W-1:0] c_imag;
    } t_point;

    typedef struct packed {
        logic             in_set;
        logic [LIM_W-1:0] iterations;
        logic [MAG_W-1:0] final_mag_sq;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE_MUL,
        ST_PRE_EVAL,
        ST_CARD_MUL,
        ST_CARD_EVAL,
        ST_ITER_MUL,
        ST_ITER_EVAL,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MUL_PRE,
        MUL_CARD,
        MUL_ITER
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     pre_eval;
        logic     iter_step;
        logic     hit_done;
        logic     loop_done;
    } t_dp_cmd;

    typedef struct packed {
        logic trivial_hit;
        logic loop_go;
    } t_dp_sts;

endpackage
`default_nettype wire

### sv/mec_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mec_datapath - arithmetic of the escape count unit
// Three registered signed multipliers shared by the cardioid/bulb test and
// the z = z*z + c iteration, plus the z, count and result registers.
// ----------------------------------------------------------------------------
module mec_datapath (
    input  wire                        i_clk,
    input  mec_pkg::t_point            i_point,
    input  wire [mec_pkg::LIM_W-1:0]   i_limit,
    input  wire [mec_pkg::MAG_W-1:0]   i_bailout,
    input  mec_pkg::t_dp_cmd           i_cmd,
    output mec_pkg::t_dp_sts           o_sts,
    output mec_pkg::t_result           o_result
);
    import mec_pkg::*;

    localparam logic signed [OP_W-1:0] QUARTER   = OP_W'(64'd1 << (FRAC_BITS - 2));
    localparam logic signed [OP_W-1:0] ONE       = OP_W'(64'd1 << FRAC_BITS);
    localparam logic [Q_W-1:0]         SIXTEENTH = Q_W'(64'd1 << (FRAC_BITS - 4));
    localparam logic [Q_W-1:0]         FOUR      = Q_W'(64'd1 << (FRAC_BITS + 2));
    localparam logic [Q_W:0]           MAG_MAX   = {2'b00, {MAG_W{1'b1}}};
    localparam logic signed [Z_W:0]    Z_MAX     = {2'b00, {(Z_W-1){1'b1}}};
    localparam logic signed [Z_W:0]    Z_MIN     = -Z_MAX;

    // saturate a grown z component back to its register range
    function automatic logic signed [Z_W-1:0] clamp_z(input logic signed [Z_W:0] v);
        logic signed [Z_W-1:0] r;
        if (v > Z_MAX) begin
            r = Z_MAX[Z_W-1:0];
        end else if (v < Z_MIN) begin
            r = Z_MIN[Z_W-1:0];
        end else begin
            r = v[Z_W-1:0];
        end
        return r;
    endfunction

    logic signed [C_W-1:0]   r_cr, r_ci;
    logic signed [Z_W-1:0]   r_x, r_y;
    logic [ITER_BITS-1:0]    r_cnt;
    logic signed [P_W-1:0]   r_p0, r_p1, r_p2;
    logic                    r_big;
    logic [Q_W-1:0]          r_q, r_yyc;
    logic                    r_bulb;
    t_result                 r_result;

    logic signed [P_W-1:0]   n_p0, n_p1, n_p2;
    logic signed [OP_W-1:0]  w_a0, w_b0, w_a1, w_b1, w_a2, w_b2;
    logic signed [OP_W-1:0]  w_cr_ext, w_ci_ext, w_x1, w_bx;
    logic signed [Q_W+1:0]   w_s;
    logic                    w_q_small, w_card_hit, w_x_fits, w_y_fits;
    logic [Q_W-1:0]          w_sq0, w_sq1, w_sq2;
    logic signed [Q_W:0]     w_lhs;
    logic [Q_W:0]            w_xx, w_yy, w_mag;
    logic signed [Z_W:0]     w_nx, w_ny;
    logic [ITER_BITS-1:0]    w_limit;
    logic                    w_loop_go;
    logic [MAG_W-1:0]        w_mag_sat;

    assign w_cr_ext = {r_cr[C_W-1], r_cr};
    assign w_ci_ext = {r_ci[C_W-1], r_ci};
    assign w_x1     = w_cr_ext - QUARTER;
    assign w_bx     = w_cr_ext + ONE;

    // squares of the pre-test are non-negative and well inside Q_W bits
    assign w_sq0 = r_p0[FRAC_BITS+Q_W-1:FRAC_BITS];
    assign w_sq1 = r_p1[FRAC_BITS+Q_W-1:FRAC_BITS];
    assign w_sq2 = r_p2[FRAC_BITS+Q_W-1:FRAC_BITS];

    // q + x1; narrow enough for the multiplier whenever q is below 4.0
    assign w_s = $signed({2'b00, r_q}) + $signed({{(Q_W+2-OP_W){w_x1[OP_W-1]}}, w_x1});

    // beyond q = 4.0 the left side always exceeds yy/4
    assign w_q_small  = (r_q < FOUR);
    assign w_lhs      = $signed(r_p0[P_W-1:FRAC_BITS]);
    assign w_card_hit = w_q_small && (w_lhs < $signed({1'b0, r_yyc >> 2}));

    assign w_x_fits = (&r_x[Z_W-1:OP_W-1]) | ~(|r_x[Z_W-1:OP_W-1]);
    assign w_y_fits = (&r_y[Z_W-1:OP_W-1]) | ~(|r_y[Z_W-1:OP_W-1]);

    always_comb begin
        w_a0 = '0;
        w_b0 = '0;
        w_a1 = '0;
        w_b1 = '0;
        w_a2 = '0;
        w_b2 = '0;
        case (i_cmd.mul_sel)
            MUL_PRE: begin
                w_a0 = w_x1;
                w_b0 = w_x1;
                w_a1 = w_ci_ext;
                w_b1 = w_ci_ext;
                w_a2 = w_bx;
                w_b2 = w_bx;
            end
            MUL_CARD: begin
                w_a0 = {{(OP_W-FRAC_BITS-2){1'b0}}, r_q[FRAC_BITS+1:0]};
                w_b0 = w_s[OP_W-1:0];
            end
            MUL_ITER: begin
                w_a0 = r_x[OP_W-1:0];
                w_b0 = r_x[OP_W-1:0];
                w_a1 = r_y[OP_W-1:0];
                w_b1 = r_y[OP_W-1:0];
                w_a2 = r_x[OP_W-1:0];
                w_b2 = r_y[OP_W-1:0];
            end
            default: begin
                w_a0 = '0;
            end
        endcase
        n_p0 = w_a0 * w_b0;
        n_p1 = w_a1 * w_b1;
        n_p2 = w_a2 * w_b2;
    end

    // iteration step; x*x and y*y are at most 2^36 when the operands fit
    assign w_xx    = r_p0[FRAC_BITS+Q_W:FRAC_BITS];
    assign w_yy    = r_p1[FRAC_BITS+Q_W:FRAC_BITS];
    assign w_mag   = w_xx + w_yy;
    assign w_limit = i_limit[ITER_BITS-1:0];

    assign w_loop_go = !r_big && (w_mag < {2'b00, i_bailout}) && (r_cnt < w_limit);

    assign w_nx = $signed({{(Z_W-Q_W){1'b0}}, w_xx}) - $signed({{(Z_W-Q_W){1'b0}}, w_yy})
                + $signed({{(Z_W+1-C_W){r_cr[C_W-1]}}, r_cr});
    assign w_ny = $signed({r_p2[FRAC_BITS+Z_W-2], r_p2[FRAC_BITS+Z_W-2:FRAC_BITS-1]})
                + $signed({{(Z_W+1-C_W){r_ci[C_W-1]}}, r_ci});

    assign w_mag_sat = (r_big || (w_mag > MAG_MAX)) ? {MAG_W{1'b1}} : w_mag[MAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cr  <= i_point.c_real;
            r_ci  <= i_point.c_imag;
            r_x   <= '0;
            r_y   <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.mul_en) begin
            r_p0  <= n_p0;
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_big <= !(w_x_fits && w_y_fits);
        end
        if (i_cmd.pre_eval) begin
            r_q    <= w_sq0 + w_sq1;
            r_yyc  <= w_sq1;
            r_bulb <= (w_sq2 + w_sq1) < SIXTEENTH;
        end
        if (i_cmd.iter_step) begin
            r_x   <= clamp_z(w_nx);
            r_y   <= clamp_z(w_ny);
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.hit_done) begin
            r_result.in_set       <= 1'b1;
            r_result.iterations   <= '0;
            r_result.final_mag_sq <= '0;
        end else if (i_cmd.loop_done) begin
            r_result.in_set       <= (r_cnt == w_limit);
            r_result.iterations   <= LIM_W'(r_cnt);
            r_result.final_mag_sq <= w_mag_sat;
        end
    end

    assign o_sts.trivial_hit = r_bulb || w_card_hit;
    assign o_sts.loop_go     = w_loop_go;
    assign o_result          = r_result;

endmodule
`default_nettype wire

### sv/mec_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mec_ctrl - sequencer of the escape count unit
// Steps one point through the cardioid/bulb test and the iteration loop,
// issuing datapath commands and presenting the result strobe.
// ----------------------------------------------------------------------------
module mec_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  mec_pkg::t_dp_sts  i_sts,
    output mec_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_result_valid
);
    import mec_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.mul_sel  = MUL_PRE;
        o_busy         = 1'b1;
        o_result_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // refuse points while reset is held
                o_busy = !i_rst_n;
                if (i_start && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_PRE_MUL;
                end
            end
            ST_PRE_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_PRE;
                n_state       = ST_PRE_EVAL;
            end
            ST_PRE_EVAL: begin
                o_cmd.pre_eval = 1'b1;
                n_state        = ST_CARD_MUL;
            end
            ST_CARD_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_CARD;
                n_state       = ST_CARD_EVAL;
            end
            ST_CARD_EVAL: begin
                if (i_sts.trivial_hit) begin
                    o_cmd.hit_done = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    n_state = ST_ITER_MUL;
                end
            end
            ST_ITER_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_ITER;
                n_state       = ST_ITER_EVAL;
            end
            ST_ITER_EVAL: begin
                // advance z while below bailout and limit, else drop out
                if (i_sts.loop_go) begin
                    o_cmd.iter_step = 1'b1;
                    n_state         = ST_ITER_MUL;
                end else begin
                    o_cmd.loop_done = 1'b1;
                    n_state         = ST_DONE;
                end
            end
            ST_DONE: begin
                o_result_valid = 1'b1;
                n_state        = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### sv/mandelbrot_escape_count_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_escape_count_unit - escape-time counter for one point c
// Tests c against the main cardioid and period-2 bulb, then iterates
// z = z*z + c until |z|^2 reaches the bailout or the count the limit.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_point and raise start; the point is taken on an edge where
//   start is high and busy is low. busy stays high until the result beat
//   has been shown.
//   The result is on o_result for exactly one cycle, marked by
//   o_result_valid; the receiver cannot hold it off.
//   From the accepting edge the unit runs the pre-test and cardioid
//   multiply/evaluate states, then strobes if c lies in the cardioid or
//   bulb, else iterates (each iteration a multiply state and an update
//   state of the shared multiplier set). One point is in flight at a time;
//   busy falls the cycle after the strobe, so a new point may follow then.
//   Registers are written over the config channel (index 0: iteration
//   limit, index 1: bailout on |z|^2), which is always ready; write them
//   only while the unit is idle. Other indexes are ignored.
//   Reset (synchronous, active low) returns the sequencer to idle and
//   loads limit 256 and bailout 4.0.
// ----------------------------------------------------------------------------
module mandelbrot_escape_count_unit (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            start,
    output logic                           busy,
    input  mec_pkg::t_point                i_point,
    output logic                           o_result_valid,
    output mec_pkg::t_result               o_result,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [mec_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [mec_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mec_pkg::*;

    logic [LIM_W-1:0] r_iter_limit;
    logic [MAG_W-1:0] r_bailout_sq;
    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter_limit <= LIMIT_RESET;
            r_bailout_sq <= BAILOUT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ITER_LIMIT: r_iter_limit <= i_cfg_data[LIM_W-1:0];
                REG_BAILOUT_SQ: r_bailout_sq <= i_cfg_data[MAG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mec_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    mec_datapath u_datapath (
        .i_clk     (i_clk),
        .i_point   (i_point),
        .i_limit   (r_iter_limit),
        .i_bailout (r_bailout_sq),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .o_result  (o_result)
    );

endmodule
`default_nettype wire

### tb/sv/mandelbrot_escape_count_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_count_unit_test - self-checking bench for the escape unit
// Drives points through the start/busy command port, predicts each result
// with a fixed-point model of the cardioid/bulb tests and the z*z + c loop,
// and checks every strobed result beat field by field, in order. Runs a
// directed set of edge points, then random points over several register
// settings, with random sender pauses in all but the closing setting.
// ----------------------------------------------------------------------------
module mandelbrot_escape_count_unit_test;
    import mec_pkg::*;

    localparam int ONE         = 1 << FRAC_BITS;
    localparam int C_MOST      = int'(32'h7FFF_FFFF);
    localparam int C_LEAST     = int'(32'h8000_0000);
    localparam int RANDOM_EACH = 325;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = '1;

    localparam longint          Z_LIMIT     = (longint'(1) << (Z_W - 1)) - 1;
    localparam logic [127:0]    PRODUCT_CAP = 128'd1 << 60;
    localparam longint unsigned MAG_MAX     = (64'd1 << MAG_W) - 64'd1;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  start          = 1'b0;
    logic                  busy;
    t_point                i_point        = '0;
    logic                  o_result_valid;
    t_result               o_result;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    // register shadow seen by the predictor
    logic [LIM_W-1:0] limit_setting   = LIMIT_RESET;
    logic [MAG_W-1:0] bailout_setting = BAILOUT_RESET;

    t_point  point_queue[$];
    t_result pending_results[$];

    logic   point_beat   = 1'b0;
    logic   pauses_on    = 1'b1;
    int     gap_left     = 0;
    int     fault_count  = 0;
    int     points_taken = 0;
    int     in_set_seen  = 0;
    int     escaped_seen = 0;
    int     longest_run  = 0;
    int     settings_run = 0;
    longint cycle_count  = 0;
    longint cycle_budget = 0;

    mandelbrot_escape_count_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_point        (i_point),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // exact a*b shifted right by s, rounded toward minus infinity, magnitude capped
    function automatic longint scaled_product(input longint a, input longint b,
                                              input int unsigned s);
        logic                neg;
        logic signed [127:0] wa, wb;
        logic [127:0]        ua, ub, prod, q;
        neg  = (a < 0) != (b < 0);
        wa   = a;
        wb   = b;
        ua   = (wa < 0) ? -wa : wa;
        ub   = (wb < 0) ? -wb : wb;
        prod = ua * ub;
        q    = prod >> s;
        if (neg && (prod & ((128'd1 << s) - 128'd1)) != 0)
            q = q + 128'd1;
        if (q > PRODUCT_CAP)
            q = PRODUCT_CAP;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint clamp_z(input longint v);
        if (v > Z_LIMIT)
            return Z_LIMIT;
        if (v < -Z_LIMIT)
            return -Z_LIMIT;
        return v;
    endfunction

    function automatic t_result escape_outcome(input t_point pt);
        longint          cr, ci, x, y, xx, yy, x1, q, bulb_sum;
        longint unsigned mag;
        int unsigned     count, lim;
        logic            trivial;
        t_result         r;
        cr  = longint'($signed(pt.c_real));
        ci  = longint'($signed(pt.c_imag));
        lim = limit_setting;

        // main cardioid, then period-2 bulb
        x1      = cr - (longint'(1) << (FRAC_BITS - 2));
        yy      = scaled_product(ci, ci, FRAC_BITS);
        q       = scaled_product(x1, x1, FRAC_BITS) + yy;
        trivial = scaled_product(q, q + x1, FRAC_BITS) < (yy >>> 2);
        x1       = cr + (longint'(1) << FRAC_BITS);
        bulb_sum = scaled_product(x1, x1, FRAC_BITS) + yy;
        if (bulb_sum < (longint'(1) << (FRAC_BITS - 4)))
            trivial = 1'b1;
        if (trivial) begin
            r = '0;
            r.in_set = 1'b1;
            return r;
        end

        x     = 0;
        y     = 0;
        count = 0;
        while (1) begin
            xx  = scaled_product(x, x, FRAC_BITS);
            yy  = scaled_product(y, y, FRAC_BITS);
            mag = unsigned'(xx) + unsigned'(yy);
            if (!(mag < 64'(bailout_setting) && count < lim))
                break;
            q     = xx - yy + cr;
            y     = clamp_z(scaled_product(x, y, FRAC_BITS - 1) + ci);
            x     = clamp_z(q);
            count = count + 1;
        end
        r.in_set       = (count == lim);
        r.iterations   = LIM_W'(count);
        r.final_mag_sq = (mag > MAG_MAX) ? MAG_W'(MAG_MAX) : MAG_W'(mag);
        return r;
    endfunction

    function automatic t_point point_at(input int re, input int im);
        t_point p;
        p.c_real = re;
        p.c_imag = im;
        return p;
    endfunction

    // sender: hold a point until taken, otherwise pause or offer the next one
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !point_beat) begin
            // hold the offered point
        end else if (gap_left != 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (point_queue.size() != 0) begin
            if (pauses_on && $urandom_range(0, 5) == 0) begin
                start    <= 1'b0;
                gap_left <= $urandom_range(0, 14);
            end else begin
                i_point <= point_queue.pop_front();
                start   <= 1'b1;
            end
        end else begin
            start <= 1'b0;
        end
    end

    // check result beats against the oldest prediction, then predict new points
    always @(posedge i_clk) begin
        t_result want;
        logic [2:0] bad;
        point_beat <= i_rst_n && start && !busy;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("%0t: result beat with nothing expected: in_set=%0b it=%0d mag=%0h",
                             $realtime, o_result.in_set, o_result.iterations,
                             o_result.final_mag_sq);
            end else begin
                want = pending_results.pop_front();
                bad  = {o_result.in_set !== want.in_set,
                        o_result.iterations !== want.iterations,
                        o_result.final_mag_sq !== want.final_mag_sq};
                if (bad != 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: mismatch %b: expected %0b %0d %0h, got %0b %0d %0h",
                                 $realtime, bad, want.in_set, want.iterations,
                                 want.final_mag_sq, o_result.in_set, o_result.iterations,
                                 o_result.final_mag_sq);
                end
            end
            if (o_result.in_set === 1'b1)
                in_set_seen++;
            else
                escaped_seen++;
        end
        if (i_rst_n && start && !busy) begin
            want = escape_outcome(i_point);
            pending_results.push_back(want);
            points_taken++;
            if (want.iterations > longest_run)
                longest_run = want.iterations;
            cycle_budget = cycle_budget + 2 * longint'(want.iterations) + 27;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 4 * cycle_budget + 50000) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            REG_ITER_LIMIT: limit_setting = value[LIM_W-1:0];
            REG_BAILOUT_SQ: bailout_setting = value[MAG_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_for_idle();
        @(posedge i_clk);
        while (point_queue.size() != 0 || start || pending_results.size() != 0 || busy)
            @(posedge i_clk);
    endtask

    // mostly points around the set and near its slow boundary, some anywhere
    task automatic random_phase(input logic [LIM_W-1:0] lim_val,
                                input logic [MAG_W-1:0] bail_val);
        int re, im, pick;
        write_register(REG_ITER_LIMIT, CFG_DATA_W'(lim_val));
        write_register(REG_BAILOUT_SQ, CFG_DATA_W'(bail_val));
        settings_run++;
        repeat (RANDOM_EACH) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                re = $urandom;
                im = $urandom;
            end else if (pick < 8) begin
                re = int'($urandom_range(0, 3 * ONE)) - 9 * (ONE / 4);
                im = int'($urandom_range(0, 3 * ONE)) - 3 * (ONE / 2);
            end else begin
                case ($urandom_range(0, 3))
                    0:       begin re = -3 * (ONE / 4);     im = ONE / 10;         end
                    1:       begin re = ONE / 4;            im = 0;                end
                    2:       begin re = -7 * (ONE / 4);     im = 0;                end
                    default: begin re = -ONE / 10;          im = 65 * (ONE / 100); end
                endcase
                re = re + int'($urandom_range(0, 1 << 23)) - (1 << 22);
                im = im + int'($urandom_range(0, 1 << 23)) - (1 << 22);
            end
            point_queue.push_back(point_at(re, im));
        end
        wait_for_idle();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        settings_run = 1;

        // reset settings: trivial hits, slow boundary points, extremes of c
        point_queue.push_back(point_at(0, 0));
        point_queue.push_back(point_at(-ONE, 0));
        point_queue.push_back(point_at(ONE / 4, 0));
        point_queue.push_back(point_at(-3 * (ONE / 4), 0));
        point_queue.push_back(point_at(-2 * ONE, 0));
        point_queue.push_back(point_at(0, ONE));
        point_queue.push_back(point_at(-7 * (ONE / 4), 0));
        point_queue.push_back(point_at(ONE / 2, 0));
        point_queue.push_back(point_at(-3 * (ONE / 4), ONE / 10));
        point_queue.push_back(point_at(C_MOST, C_MOST));
        point_queue.push_back(point_at(C_LEAST, C_LEAST));
        point_queue.push_back(point_at(C_MOST, C_LEAST));
        point_queue.push_back(point_at(C_LEAST, C_MOST));
        point_queue.push_back(point_at(0, C_LEAST));
        point_queue.push_back(point_at(C_LEAST, 0));
        wait_for_idle();

        // zero limit: the loop never runs
        write_register(REG_ITER_LIMIT, '0);
        point_queue.push_back(point_at(ONE / 2, 0));
        point_queue.push_back(point_at(C_MOST, C_MOST));
        point_queue.push_back(point_at(0, 0));
        wait_for_idle();

        // zero bailout with the smallest nonzero limit
        write_register(REG_ITER_LIMIT, CFG_DATA_W'(1));
        write_register(REG_BAILOUT_SQ, '0);
        point_queue.push_back(point_at(ONE / 2, 0));
        point_queue.push_back(point_at(0, ONE));
        point_queue.push_back(point_at(0, 0));
        wait_for_idle();
        write_register(REG_BAILOUT_SQ, CFG_DATA_W'(BAILOUT_RESET));
        point_queue.push_back(point_at(ONE / 2, 0));
        point_queue.push_back(point_at(3 * ONE, 0));
        wait_for_idle();

        // largest limit and bailout; upper data bits of the limit write are junk
        write_register(REG_ITER_LIMIT, '1);
        write_register(REG_BAILOUT_SQ, '1);
        point_queue.push_back(point_at(0, ONE));
        point_queue.push_back(point_at(2 * ONE, 2 * ONE));
        point_queue.push_back(point_at(C_MOST, C_LEAST));
        wait_for_idle();

        // unmapped indexes must leave both registers alone
        write_register(REG_ITER_LIMIT, {20'hA5A5A, 16'd64});
        write_register(REG_UNMAPPED_LO, CFG_DATA_W'(5));
        write_register(REG_UNMAPPED_HI, '0);
        point_queue.push_back(point_at(0, ONE));
        point_queue.push_back(point_at(-3 * (ONE / 4), ONE / 10));
        wait_for_idle();
        settings_run = settings_run + 5;

        random_phase(LIMIT_RESET, BAILOUT_RESET);
        random_phase(LIM_W'(64), MAG_W'(64'd1 << 32));
        random_phase(LIM_W'(1000), MAG_W'(64'd1 << FRAC_BITS));
        random_phase(LIM_W'(24), {4'($urandom_range(0, 15)), 32'($urandom)});
        random_phase(LIM_W'($urandom_range(1, 400)),
                     (MAG_W'($urandom_range(1, 63)) << FRAC_BITS) |
                     MAG_W'($urandom_range(0, ONE - 1)));
        // closing stretch without sender pauses
        pauses_on = 1'b0;
        random_phase(LIM_W'(128), BAILOUT_RESET);

        repeat (300) @(posedge i_clk);
        if (pending_results.size() != 0)
            fault_count = fault_count + pending_results.size();

        $display("Checked %0d points over %0d register settings: %0d in the set, %0d escaped",
                 points_taken, settings_run, in_set_seen, escaped_seen);
        $display("Longest orbit %0d iterations, %0d faults", longest_run, fault_count);
        if (fault_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
